// ===== rtl/core/sorted_priority_queue_assert.svh =====
// Assertion macros for the sorted priority queue.
// Included by the modules that carry concurrent checks; needs clock and reset in scope.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// expression holds at every edge outside reset
`define SPQ_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent holds at the edge after the antecedent
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/spq_pkg.sv =====
// Shared types and constants of the sorted priority queue.
// No dependencies.
package spq_pkg;

   localparam int CAPACITY      = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int COUNT_BITS    = $clog2(CAPACITY + 1);
   localparam int OCC_BITS      = 5;

   localparam logic [7:0] PRIO_MASK =
      (PRIORITY_BITS >= 8) ? 8'hFF : 8'((1 << PRIORITY_BITS) - 1);

   typedef enum logic [1:0] {
      FUNC_ENQ  = 2'd0,
      FUNC_DEQ  = 2'd1,
      FUNC_PEEK = 2'd2,
      FUNC_RSVD = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RSVD  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] item_value;
      logic [7:0]         item_priority;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  head_value;
      logic [7:0]          head_priority;
      logic                head_valid;
      logic [1:0]          status;
      logic [OCC_BITS-1:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [7:0]         prio;
   } entry_type;

   // broadcast to every cell
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type item;
   } ctrl_type;

endpackage

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and a used mark.
// Depends on spq_pkg; neighbours are wired by the top level.
module spq_cell import spq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  ctrl_type  ctrl,
   input  entry_type left_entry,
   input  logic      left_used,
   input  logic      left_keep,
   input  entry_type right_entry,
   input  logic      right_used,
   output entry_type entry,
   output logic      used,
   output logic      keep
);

   entry_type entry_ff, entry_in;
   logic      used_ff, used_in;

   assign keep = used_ff && (entry_ff.prio <= ctrl.item.prio);

   always_comb begin
      entry_in = entry_ff;
      used_in  = used_ff;
      if (ctrl.enq) begin
         used_in = used_ff | left_used;
         if (!keep) begin
            entry_in = left_keep ? ctrl.item : left_entry;
         end
      end else if (ctrl.deq) begin
         used_in  = right_used;
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   assign entry = entry_ff;
   assign used  = used_ff;

endmodule

// ===== rtl/core/spq_rsp_buf.sv =====
// Result output register with a skid stage behind it.
// Depends on spq_pkg and sorted_priority_queue_assert.svh.
`include "sorted_priority_queue_assert.svh"

module spq_rsp_buf import spq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    busy,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   rsp_type out_ff, skid_ff;
   logic    out_valid_ff, skid_valid_ff;
   logic    taken;

   assign taken = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (taken) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= in_valid;
               out_ff       <= in_data;
            end
         end else if (out_valid_ff) begin
            if (in_valid) begin
               skid_ff       <= in_data;
               skid_valid_ff <= 1'b1;
            end
         end else begin
            out_valid_ff <= in_valid;
            out_ff       <= in_data;
         end
      end
   end

   assign busy      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `SPQ_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_ff || out_valid_ff,
      "skid beat held with empty output register")
   `SPQ_ASSERT_NEXT(a_skid_drains, skid_valid_ff && taken, !skid_valid_ff,
      "skid beat not moved forward")

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// Sorted priority queue: top level, chain of slot cells and result buffer.
// Depends on spq_pkg, spq_cell, spq_rsp_buf and sorted_priority_queue_assert.svh.
//
// Request channel (req_valid, req_stall, req_data): one beat asks for an
// enqueue, a dequeue of the head or a peek (code 3 acts as a peek).
// Response channel (rsp_valid, rsp_stall, rsp_data): exactly one beat per
// request, in request order, carrying the head after the operation (the
// removed entry on dequeue), a status and the occupancy.
// Each slot cell compares the new priority against its own entry, so the whole
// chain takes an enqueue or dequeue in parallel; ties keep arrival order.
// The response of an accepted request goes to the output register, or to the skid stage while the output is held.
// Throughput: one request per cycle while the receiver keeps taking beats.
// A stalled response is held; one further request is taken into the skid
// stage, then req_stall rises until the output drains.
// Reset empties the queue (all used marks and the count cleared) and
// drops any pending response. A full enqueue is dropped with status full.
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue import spq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   entry_type             cell_entry [CAPACITY];
   logic [CAPACITY-1:0]   cell_used;
   logic [CAPACITY-1:0]   cell_keep;
   ctrl_type              ctrl;
   logic                  accept, full, empty, buf_busy;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   rsp_type               rsp_new;

   assign req_stall = buf_busy;
   assign accept    = req_valid && !buf_busy;
   assign full      = cell_used[CAPACITY-1];
   assign empty     = !cell_used[0];

   always_comb begin
      ctrl.item.value = req_data.item_value;
      ctrl.item.prio  = req_data.item_priority & PRIO_MASK;
      ctrl.enq = accept && (req_data.func == FUNC_ENQ) && !full;
      ctrl.deq = accept && (req_data.func == FUNC_DEQ) && !empty;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_entry, right_entry;
      logic      left_used, left_keep, right_used;
      if (i == 0) begin : g_first
         assign left_entry = ctrl.item;
         assign left_used  = 1'b1;
         assign left_keep  = 1'b1;
      end else begin : g_inner
         assign left_entry = cell_entry[i-1];
         assign left_used  = cell_used[i-1];
         assign left_keep  = cell_keep[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = cell_entry[i];
         assign right_used  = 1'b0;
      end else begin : g_mid
         assign right_entry = cell_entry[i+1];
         assign right_used  = cell_used[i+1];
      end
      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .left_used   (left_used),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .right_used  (right_used),
         .entry       (cell_entry[i]),
         .used        (cell_used[i]),
         .keep        (cell_keep[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.enq) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      rsp_new.head_value    = cell_entry[0].value;
      rsp_new.head_priority = cell_entry[0].prio;
      rsp_new.head_valid    = 1'b1;
      rsp_new.status        = STATUS_OK;
      rsp_new.occupancy     = OCC_BITS'(count_in);
      case (func_type'(req_data.func))
         FUNC_ENQ: begin
            if (full) begin
               rsp_new.status = STATUS_FULL;
            end else if (!cell_keep[0]) begin
               rsp_new.head_value    = ctrl.item.value;
               rsp_new.head_priority = ctrl.item.prio;
            end
         end
         default: begin
            if (empty) begin
               rsp_new.head_value    = '0;
               rsp_new.head_priority = '0;
               rsp_new.head_valid    = 1'b0;
               rsp_new.status        = STATUS_EMPTY;
            end
         end
      endcase
   end

   spq_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (rsp_new),
      .busy      (buf_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `SPQ_ASSERT_ALWAYS(a_count_matches, count_ff == COUNT_BITS'($countones(cell_used)),
      "entry count differs from used marks")
   `SPQ_ASSERT_ALWAYS(a_used_prefix, (cell_used & (cell_used + 1'b1)) == '0,
      "used marks not packed towards the head")
   `SPQ_ASSERT_NEXT(a_enq_grows, ctrl.enq, count_ff == $past(count_ff) + 1'b1,
      "enqueue did not add one entry")
   `SPQ_ASSERT_NEXT(a_deq_shrinks, ctrl.deq, count_ff == $past(count_ff) - 1'b1,
      "dequeue did not remove one entry")

endmodule

// ===== test/sorted_priority_queue_tb.sv =====
// Self-checking testbench for sorted_priority_queue: directed table, then random traffic.
// Expected beats: bench's shadow sorted list or fixed table rows; depends on spq_pkg.
module sorted_priority_queue_tb import spq_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 10;
   localparam int RANDOM_ITEMS = 1630;
   localparam int LONG_HOLD    = 64;
   localparam int HOLD_BURST   = 40;
   localparam int DRAIN_CYCLES = 10;
   localparam int IDLE_LIMIT   = 1000;

   typedef struct {
      req_type req;
      bit      fixed;
      rsp_type want;
   } dir_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic signed [31:0] shadow_value [CAPACITY];
   logic [7:0]         shadow_prio [CAPACITY];
   int                 shadow_count = 0;

   rsp_type     pending_heads [$];
   dir_row_type dir_rows [$];
   int          error_count = 0;
   int          beat_count  = 0;
   int          idle_cycles = 0;
   int          burst_left  = 0;
   bit          long_hold   = 1'b0;

   sorted_priority_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   task automatic flag_error(string msg);
      $display("ERROR beat %0d: %s", beat_count, msg);
      error_count++;
   endtask

   function automatic rsp_type head_rsp(logic [31:0] v, logic [7:0] p, logic valid,
                                        status_type st, int occ);
      rsp_type r;
      r.head_value    = v;
      r.head_priority = p;
      r.head_valid    = valid;
      r.status        = st;
      r.occupancy     = OCC_BITS'(occ);
      return r;
   endfunction

   function automatic rsp_type current_head(status_type st);
      if (shadow_count == 0) return head_rsp('0, '0, 1'b0, STATUS_EMPTY, 0);
      return head_rsp(shadow_value[0], shadow_prio[0], 1'b1, st, shadow_count);
   endfunction

   function automatic rsp_type predict_head(req_type r);
      logic [7:0]         prio;
      logic signed [31:0] hv;
      logic [7:0]         hp;
      int                 pos;
      prio = r.item_priority & PRIO_MASK;
      case (r.func)
         FUNC_ENQ: begin
            if (shadow_count >= CAPACITY) return current_head(STATUS_FULL);
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
            for (int i = shadow_count; i > pos; i--) begin
               shadow_value[i] = shadow_value[i-1];
               shadow_prio[i]  = shadow_prio[i-1];
            end
            shadow_value[pos] = r.item_value;
            shadow_prio[pos]  = prio;
            shadow_count++;
            return current_head(STATUS_OK);
         end
         FUNC_DEQ: begin
            if (shadow_count == 0) return current_head(STATUS_EMPTY);
            hv = shadow_value[0];
            hp = shadow_prio[0];
            for (int i = 0; i + 1 < shadow_count; i++) begin
               shadow_value[i] = shadow_value[i+1];
               shadow_prio[i]  = shadow_prio[i+1];
            end
            shadow_count--;
            return head_rsp(hv, hp, 1'b1, STATUS_OK, shadow_count);
         end
         default: return current_head(STATUS_OK);
      endcase
   endfunction

   function automatic dir_row_type dir_row(func_type f, logic [31:0] v, logic [7:0] p,
                                           bit fixed = 1'b0, rsp_type want = '0);
      dir_row_type d;
      d.req.func          = f;
      d.req.item_value    = v;
      d.req.item_priority = p;
      d.fixed             = fixed;
      d.want              = want;
      return d;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic req_type random_req(int enq_pct, int prio_mode);
      req_type r;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < enq_pct) r.func = FUNC_ENQ;
      else begin
         pick = $urandom_range(0, 9);
         if (pick < 7)      r.func = FUNC_DEQ;
         else if (pick < 9) r.func = FUNC_PEEK;
         else               r.func = FUNC_RSVD;
      end
      case ($urandom_range(0, 15))
         0:       r.item_value = 32'sh8000_0000;
         1:       r.item_value = 32'sh7FFF_FFFF;
         2:       r.item_value = '0;
         3:       r.item_value = '1;
         default: r.item_value = $urandom;
      endcase
      case (prio_mode)
         0:       r.item_priority = $urandom_range(0, 255);
         1:       r.item_priority = $urandom_range(0, 3);
         default: r.item_priority = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
      return r;
   endfunction

   task automatic send_req(req_type r, bit fixed, rsp_type want);
      int      gap;
      rsp_type model;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      model = predict_head(r);
      pending_heads.push_back(fixed ? want : model);
   endtask

   // receiver side
   initial begin
      int n;
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            n = pick_gap();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_heads.size() == 0) begin
            flag_error("response beat with nothing pending");
         end else begin
            want = pending_heads.pop_front();
            if (rsp_data.head_value !== want.head_value)
               flag_error($sformatf("head_value got %0d expected %0d",
                                    rsp_data.head_value, want.head_value));
            if (rsp_data.head_priority !== want.head_priority)
               flag_error($sformatf("head_priority got %0d expected %0d",
                                    rsp_data.head_priority, want.head_priority));
            if (rsp_data.head_valid !== want.head_valid)
               flag_error($sformatf("head_valid got %b expected %b",
                                    rsp_data.head_valid, want.head_valid));
            if (rsp_data.status !== want.status)
               flag_error($sformatf("status got %0d expected %0d",
                                    rsp_data.status, want.status));
            if (rsp_data.occupancy !== want.occupancy)
               flag_error($sformatf("occupancy got %0d expected %0d",
                                    rsp_data.occupancy, want.occupancy));
         end
         beat_count++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d pending",
                  idle_cycles, pending_heads.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int  sent;
      int  block;
      int  enq_pct;
      int  prio_mode;
      bit  hold_done;

      dir_rows.push_back(dir_row(FUNC_PEEK, 32'h0, 8'h0, 1'b1,
                                 head_rsp('0, '0, 1'b0, STATUS_EMPTY, 0)));
      dir_rows.push_back(dir_row(FUNC_DEQ, 32'hFFFF_FFFF, 8'hFF, 1'b1,
                                 head_rsp('0, '0, 1'b0, STATUS_EMPTY, 0)));
      dir_rows.push_back(dir_row(FUNC_RSVD, 32'h1234_5678, 8'h12, 1'b1,
                                 head_rsp('0, '0, 1'b0, STATUS_EMPTY, 0)));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'h7FFF_FFFF, 8'hFF, 1'b1,
                                 head_rsp(32'h7FFF_FFFF, 8'hFF, 1'b1, STATUS_OK, 1)));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'h8000_0000, 8'h00, 1'b1,
                                 head_rsp(32'h8000_0000, 8'h00, 1'b1, STATUS_OK, 2)));
      // ties at both ends keep arrival order
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'h0000_0001, 8'h00));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'hFFFF_FFFF, 8'hFF));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'h0000_0080, 8'd128));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'h0000_0040, 8'd64));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'h0000_00C8, 8'd200));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'h0000_0007, 8'd7));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'hFFFF_FFF9, 8'd7));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'h0000_0101, 8'd1));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'h0000_00FE, 8'd254));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'h0000_0064, 8'd100));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'h0000_0003, 8'd3));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'h0000_0041, 8'd64));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'h5555_AAAA, 8'h55));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'hAAAA_5555, 8'hAA));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'h0BAD_0BAD, 8'h01, 1'b1,
                                 head_rsp(32'h8000_0000, 8'h00, 1'b1, STATUS_FULL, 16)));
      dir_rows.push_back(dir_row(FUNC_RSVD, 32'h0, 8'h0));
      dir_rows.push_back(dir_row(FUNC_DEQ, 32'h0, 8'h0));
      dir_rows.push_back(dir_row(FUNC_PEEK, 32'h0, 8'h0));
      dir_rows.push_back(dir_row(FUNC_DEQ, 32'h0, 8'h0));
      dir_rows.push_back(dir_row(FUNC_ENQ, 32'h0000_0000, 8'h00));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].want);

      sent      = 0;
      hold_done = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         block = $urandom_range(8, 60);
         case ($urandom_range(0, 3))
            0:       enq_pct = 85;
            1:       enq_pct = 20;
            2:       enq_pct = 50;
            default: enq_pct = 60;
         endcase
         prio_mode = $urandom_range(0, 2);
         if (sent == 0 || $urandom_range(0, 9) == 0) begin
            // sender waits for the queue of results to drain
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_heads.size() != 0);
         end
         if (!hold_done && sent > RANDOM_ITEMS / 3) begin
            long_hold  = 1'b1;
            burst_left = HOLD_BURST;
            hold_done  = 1'b1;
         end
         repeat (block) begin
            send_req(random_req(enq_pct, prio_mode), 1'b0, '0);
            sent++;
         end
      end

      req_valid <= 1'b0;
      while (pending_heads.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_heads.size() != 0)
         flag_error($sformatf("%0d results never arrived", pending_heads.size()));

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
